// ===== hw/rtl/bru_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bru_pkg;

    // instruction forms
    typedef logic [3:0] mode_t;
    localparam mode_t MODE_JMP_REL  = 4'd0;
    localparam mode_t MODE_JMP_REG  = 4'd1;
    localparam mode_t MODE_JMP_MEM  = 4'd2;
    localparam mode_t MODE_JCC      = 4'd3;
    localparam mode_t MODE_CALL_REL = 4'd4;
    localparam mode_t MODE_CALL_REG = 4'd5;
    localparam mode_t MODE_CALL_MEM = 4'd6;
    localparam mode_t MODE_RET      = 4'd7;
    localparam mode_t MODE_LOOP     = 4'd8;
    localparam mode_t MODE_LOOPE    = 4'd9;
    localparam mode_t MODE_LOOPNE   = 4'd10;
    localparam mode_t MODE_JCXZ     = 4'd11;

    // condition groups, selected by the upper three bits of the condition nibble
    localparam logic [2:0] CC_O  = 3'd0;
    localparam logic [2:0] CC_B  = 3'd1;
    localparam logic [2:0] CC_E  = 3'd2;
    localparam logic [2:0] CC_BE = 3'd3;
    localparam logic [2:0] CC_S  = 3'd4;
    localparam logic [2:0] CC_P  = 3'd5;
    localparam logic [2:0] CC_L  = 3'd6;
    localparam logic [2:0] CC_LE = 3'd7;

    // flag bit positions
    localparam int FLAG_CF = 0;
    localparam int FLAG_PF = 1;
    localparam int FLAG_ZF = 2;
    localparam int FLAG_SF = 3;
    localparam int FLAG_OF = 4;

    // stack slot size and return pop mask
    localparam logic [63:0] SLOT_BYTES   = 64'd8;
    localparam logic [15:0] RET_POP_MASK = 16'hFFFF;

    // beat after the address stage
    typedef struct packed {
        mode_t       mode;
        logic [63:0] insn_addr;
        logic [63:0] fall;
        logic [63:0] disp_ext;
        logic [63:0] reg_value;
        logic [63:0] mem_value;
        logic        mem_ok;
        logic        cond_hit;
        logic        zf;
        logic        count_zero;
        logic [63:0] count_reg;
        logic [63:0] count_dec;
        logic [63:0] stack_ptr;
        logic [63:0] sp_push;
        logic [63:0] sp_pop;
    } s1_t;

    // beat after the target stage
    typedef struct packed {
        mode_t       mode;
        logic [63:0] insn_addr;
        logic [63:0] fall;
        logic [63:0] rel;
        logic [63:0] reg_value;
        logic [63:0] mem_value;
        logic        mem_ok;
        logic        take_cond;
        logic [63:0] count_reg;
        logic [63:0] count_dec;
        logic [63:0] stack_ptr;
        logic [63:0] sp_push;
        logic [63:0] sp_pop;
    } s2_t;

    // resolved result
    typedef struct packed {
        logic [63:0] next_addr;
        logic        taken;
        logic [63:0] new_count;
        logic [63:0] new_stack_ptr;
        logic        push_valid;
        logic [63:0] push_data;
        logic        fault;
    } res_t;

    // jcc condition evaluation
    function automatic logic cond_true(input logic [3:0] cc, input logic [4:0] fl);
        logic r;
        r = 1'b0;
        case (cc[3:1])
            CC_O:    r = fl[FLAG_OF];
            CC_B:    r = fl[FLAG_CF];
            CC_E:    r = fl[FLAG_ZF];
            CC_BE:   r = fl[FLAG_CF] | fl[FLAG_ZF];
            CC_S:    r = fl[FLAG_SF];
            CC_P:    r = fl[FLAG_PF];
            CC_L:    r = fl[FLAG_SF] ^ fl[FLAG_OF];
            CC_LE:   r = fl[FLAG_ZF] | (fl[FLAG_SF] ^ fl[FLAG_OF]);
            default: r = 1'b0;
        endcase
        return cc[0] ? ~r : r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bru_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bru_decode (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire  [3:0]         mode,
    input  wire  [63:0]        insn_addr,
    input  wire  [3:0]         insn_len,
    input  wire  signed [31:0] displacement,
    input  wire  [63:0]        reg_value,
    input  wire  [63:0]        mem_value,
    input  wire                mem_ok,
    input  wire  [3:0]         cond_code,
    input  wire  [4:0]         flags_in,
    input  wire  [63:0]        count_reg,
    input  wire  [63:0]        stack_ptr,
    output logic               s1_valid,
    input  wire                s1_ready,
    output bru_pkg::s1_t       s1
);
    import bru_pkg::*;

    logic valid_reg;
    s1_t  data_reg;
    s1_t  data_next;

    // fall-through, sign extension, condition evaluation, count and stack arithmetic
    always_comb
    begin
        data_next.mode       = mode;
        data_next.insn_addr  = insn_addr;
        data_next.fall       = insn_addr + {60'd0, insn_len};
        data_next.disp_ext   = {{32{displacement[31]}}, displacement};
        data_next.reg_value  = reg_value;
        data_next.mem_value  = mem_value;
        data_next.mem_ok     = mem_ok;
        data_next.cond_hit   = cond_true(cond_code, flags_in);
        data_next.zf         = flags_in[FLAG_ZF];
        data_next.count_zero = (count_reg == 64'd0);
        data_next.count_reg  = count_reg;
        data_next.count_dec  = count_reg - 64'd1;
        data_next.stack_ptr  = stack_ptr;
        data_next.sp_push    = stack_ptr - SLOT_BYTES;
        data_next.sp_pop     = stack_ptr + SLOT_BYTES
                             + {48'd0, displacement[15:0] & RET_POP_MASK};
    end

    assign in_ready = ~valid_reg | s1_ready;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign s1_valid = valid_reg;
    assign s1       = data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bru_target.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bru_target (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s1_valid,
    output logic         s1_ready,
    input  wire  bru_pkg::s1_t s1,
    output logic         s2_valid,
    input  wire          s2_ready,
    output bru_pkg::s2_t s2
);
    import bru_pkg::*;

    logic valid_reg;
    s2_t  data_reg;
    s2_t  data_next;
    logic dec_nz;

    // relative target and branch condition per form
    always_comb
    begin
        dec_nz               = (s1.count_dec != 64'd0);
        data_next.mode       = s1.mode;
        data_next.insn_addr  = s1.insn_addr;
        data_next.fall       = s1.fall;
        data_next.rel        = s1.fall + s1.disp_ext;
        data_next.reg_value  = s1.reg_value;
        data_next.mem_value  = s1.mem_value;
        data_next.mem_ok     = s1.mem_ok;
        data_next.count_reg  = s1.count_reg;
        data_next.count_dec  = s1.count_dec;
        data_next.stack_ptr  = s1.stack_ptr;
        data_next.sp_push    = s1.sp_push;
        data_next.sp_pop     = s1.sp_pop;
        case (s1.mode)
            MODE_JCC:    data_next.take_cond = s1.cond_hit;
            MODE_LOOP:   data_next.take_cond = dec_nz;
            MODE_LOOPE:  data_next.take_cond = dec_nz & s1.zf;
            MODE_LOOPNE: data_next.take_cond = dec_nz & ~s1.zf;
            MODE_JCXZ:   data_next.take_cond = s1.count_zero;
            default:     data_next.take_cond = 1'b0;
        endcase
    end

    assign s1_ready = ~valid_reg | s2_ready;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            valid_reg <= s1_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (s1_valid && s1_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign s2_valid = valid_reg;
    assign s2       = data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bru_resolve.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bru_resolve (
    input  wire           clk,
    input  wire           rst_n,
    input  wire           s2_valid,
    output logic          s2_ready,
    input  wire  bru_pkg::s2_t s2,
    output logic          res_valid,
    input  wire           res_ready,
    output bru_pkg::res_t res
);
    import bru_pkg::*;

    logic valid_reg;
    res_t data_reg;
    res_t data_next;

    // final selection of target, registers and fault
    always_comb
    begin
        data_next.next_addr     = s2.fall;
        data_next.taken         = 1'b0;
        data_next.new_count     = s2.count_reg;
        data_next.new_stack_ptr = s2.stack_ptr;
        data_next.push_valid    = 1'b0;
        data_next.push_data     = 64'd0;
        data_next.fault         = 1'b0;
        case (s2.mode)
            MODE_JMP_REL:
            begin
                data_next.next_addr = s2.rel;
                data_next.taken     = 1'b1;
            end
            MODE_JMP_REG:
            begin
                data_next.next_addr = s2.reg_value;
                data_next.taken     = 1'b1;
            end
            MODE_JMP_MEM:
            begin
                if (s2.mem_ok)
                begin
                    data_next.next_addr = s2.mem_value;
                    data_next.taken     = 1'b1;
                end
                else
                begin
                    data_next.fault = 1'b1;
                end
            end
            MODE_CALL_REL, MODE_CALL_REG, MODE_CALL_MEM:
            begin
                if (s2.mem_ok)
                begin
                    data_next.new_stack_ptr = s2.sp_push;
                    data_next.push_valid    = 1'b1;
                    data_next.push_data     = s2.fall;
                    data_next.taken         = 1'b1;
                    if (s2.mode == MODE_CALL_REL)
                    begin
                        data_next.next_addr = s2.rel;
                    end
                    else if (s2.mode == MODE_CALL_REG)
                    begin
                        data_next.next_addr = s2.reg_value;
                    end
                    else
                    begin
                        data_next.next_addr = s2.mem_value;
                    end
                end
                else
                begin
                    data_next.fault = 1'b1;
                end
            end
            MODE_RET:
            begin
                if (s2.mem_ok)
                begin
                    data_next.new_stack_ptr = s2.sp_pop;
                    data_next.next_addr     = s2.mem_value;
                    data_next.taken         = 1'b1;
                end
                else
                begin
                    data_next.fault = 1'b1;
                end
            end
            MODE_LOOP, MODE_LOOPE, MODE_LOOPNE:
            begin
                data_next.new_count = s2.count_dec;
                if (s2.take_cond)
                begin
                    data_next.next_addr = s2.rel;
                    data_next.taken     = 1'b1;
                end
            end
            MODE_JCC, MODE_JCXZ:
            begin
                if (s2.take_cond)
                begin
                    data_next.next_addr = s2.rel;
                    data_next.taken     = 1'b1;
                end
            end
            default:
            begin
                data_next.taken = 1'b0;
            end
        endcase
        // a faulting instruction points back at itself
        if (data_next.fault)
        begin
            data_next.next_addr = s2.insn_addr;
        end
    end

    assign s2_ready = ~valid_reg | res_ready;

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            valid_reg <= s2_valid;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (s2_valid && s2_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign res_valid = valid_reg;
    assign res       = data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/x86_branch_resolve_unit.sv =====
// branch resolve unit: one control-flow instruction per beat
// pipeline: address, target and resolve stages in that order, each registering its beat
// throughput: one beat per cycle; each stage holds its beat while the next is full
// reset: rst_n asynchronous, active low, clears all stage valid bits
`timescale 1ns / 1ps
`default_nettype none

module x86_branch_resolve_unit (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire  [3:0]         mode,
    input  wire  [63:0]        insn_addr,
    input  wire  [3:0]         insn_len,
    input  wire  signed [31:0] displacement,
    input  wire  [63:0]        reg_value,
    input  wire  [63:0]        mem_value,
    input  wire                mem_ok,
    input  wire  [3:0]         cond_code,
    input  wire  [4:0]         flags_in,
    input  wire  [63:0]        count_reg,
    input  wire  [63:0]        stack_ptr,
    output logic               out_valid,
    input  wire                out_ready,
    output logic [63:0]        next_addr,
    output logic               taken,
    output logic [63:0]        new_count,
    output logic [63:0]        new_stack_ptr,
    output logic               push_valid,
    output logic [63:0]        push_data,
    output logic               fault
);
    import bru_pkg::*;

    logic s1_valid;
    logic s1_ready;
    s1_t  s1;
    logic s2_valid;
    logic s2_ready;
    s2_t  s2;
    res_t res;

    // address stage
    bru_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .insn_addr    (insn_addr),
        .insn_len     (insn_len),
        .displacement (displacement),
        .reg_value    (reg_value),
        .mem_value    (mem_value),
        .mem_ok       (mem_ok),
        .cond_code    (cond_code),
        .flags_in     (flags_in),
        .count_reg    (count_reg),
        .stack_ptr    (stack_ptr),
        .s1_valid     (s1_valid),
        .s1_ready     (s1_ready),
        .s1           (s1)
    );

    // target stage
    bru_target u_target (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1_ready (s1_ready),
        .s1       (s1),
        .s2_valid (s2_valid),
        .s2_ready (s2_ready),
        .s2       (s2)
    );

    // resolve stage
    bru_resolve u_resolve (
        .clk       (clk),
        .rst_n     (rst_n),
        .s2_valid  (s2_valid),
        .s2_ready  (s2_ready),
        .s2        (s2),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (res)
    );

    assign next_addr     = res.next_addr;
    assign taken         = res.taken;
    assign new_count     = res.new_count;
    assign new_stack_ptr = res.new_stack_ptr;
    assign push_valid    = res.push_valid;
    assign push_data     = res.push_data;
    assign fault         = res.fault;

    // a fault never transfers control or pushes
    a_fault_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault |-> !taken && !push_valid && push_data == 64'd0)
        else $error("fault beat with side effects");

    // a push only comes with a taken, non-faulting call
    a_push_taken: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && push_valid |-> taken && !fault)
        else $error("push without taken call");

    // push data is zero whenever nothing is pushed
    a_push_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !push_valid |-> push_data == 64'd0)
        else $error("push data without push");

    // a stalled target stage never loses its beat
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid && !s2_ready |=> s2_valid)
        else $error("target stage dropped a beat");

endmodule

`default_nettype wire
